// File: design/g711_expand_upsample2x_defines.svh
// Assertion macros used by the top-level expander.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef G711_EXPAND_UPSAMPLE2X_DEFINES_SVH
`define G711_EXPAND_UPSAMPLE2X_DEFINES_SVH

// Same-cycle implication.
`define G7E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define G7E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/g7e_pkg.sv
// Shared types and constants of the G.711 expander with 2x interpolator.
// No dependencies.
`default_nettype none

package g7e_pkg;

  localparam int unsigned PosW    = 13;
  localparam int unsigned SampleW = 16;

  // Companding constants
  localparam logic [7:0] MuBias       = 8'h84;
  localparam logic [7:0] AlawXor      = 8'h55;
  localparam logic [8:0] AlawSegBias  = 9'h108;
  localparam logic [8:0] AlawSeg0Bias = 9'h008;

  typedef enum logic {
    LawAlaw  = 1'b0,
    LawMulaw = 1'b1
  } law_e;

  typedef enum logic [1:0] {
    CfgLawSelect     = 2'd0,
    CfgUpsampleEn    = 2'd1,
    CfgFrameLength   = 2'd2
  } cfg_idx_e;

  localparam logic [PosW-1:0] FrameLenReset = 13'd1024;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               item_last;
    logic               frame_last;
  } beat_t;

  typedef struct packed {
    beat_t [2:0] beats;
    logic  [1:0] last_idx;
    logic        frame_end;
  } plan_t;

endpackage

`default_nettype wire

// File: design/g7e_expand.sv
// G.711 code byte to 16-bit linear sample, mu-law or A-law.
// Depends on g7e_pkg.
`default_nettype none

module g7e_expand (
  input  wire logic [7:0]          code_i,
  input  wire g7e_pkg::law_e       law_i,
  output logic [g7e_pkg::SampleW-1:0] sample_o
);

  logic [7:0]  mu_u;
  logic [7:0]  mu_base;
  logic [14:0] mu_shift;
  logic [15:0] mu_mag;
  logic [15:0] mu_s;

  logic [7:0]  al_a;
  logic [8:0]  al_t;
  logic [2:0]  al_seg_m1;
  logic [15:0] al_mag;
  logic [15:0] al_s;

  always_comb begin
    mu_u     = ~code_i;
    mu_base  = {1'b0, mu_u[3:0], 3'b000} + g7e_pkg::MuBias;
    mu_shift = 15'(mu_base) << mu_u[6:4];
    mu_mag   = {1'b0, mu_shift - 15'(g7e_pkg::MuBias)};
    mu_s     = mu_u[7] ? (~mu_mag + 16'd1) : mu_mag;
  end

  always_comb begin
    al_a      = code_i ^ g7e_pkg::AlawXor;
    al_t      = {1'b0, al_a[3:0], 4'b0000};
    al_seg_m1 = al_a[6:4] - 3'd1;
    if (al_a[6:4] == 3'd0) begin
      al_mag = 16'(al_t + g7e_pkg::AlawSeg0Bias);
    end else begin
      al_mag = 16'(al_t + g7e_pkg::AlawSegBias) << al_seg_m1;
    end
    // sign bit set means positive in A-law
    al_s = al_a[7] ? al_mag : (~al_mag + 16'd1);
  end

  assign sample_o = (law_i == g7e_pkg::LawMulaw) ? mu_s : al_s;

endmodule

`default_nettype wire

// File: design/g7e_plan.sv
// Frame tracking and beat planning for one expanded sample: midpoint,
// repeat of the frame's last sample, last flags. Depends on g7e_pkg.
`default_nettype none

module g7e_plan #(
  parameter int unsigned FRAME_LEN_MAX = 4096
) (
  input  wire logic [g7e_pkg::SampleW-1:0] sample_i,
  input  wire logic [g7e_pkg::SampleW-1:0] held_i,
  input  wire logic [g7e_pkg::PosW-1:0]    pos_i,
  input  wire logic [g7e_pkg::PosW-1:0]    frame_len_i,
  input  wire logic                        upsample_i,
  output g7e_pkg::plan_t                   plan_o
);

  localparam int unsigned PosMax = (1 << g7e_pkg::PosW) - 1;
  localparam logic [g7e_pkg::PosW-1:0] LenCap =
    (FRAME_LEN_MAX > PosMax) ? g7e_pkg::PosW'(PosMax) : g7e_pkg::PosW'(FRAME_LEN_MAX);

  logic [g7e_pkg::PosW-1:0]    len;
  logic                        first;
  logic                        last;
  logic [g7e_pkg::SampleW:0]   sum;
  logic [g7e_pkg::SampleW:0]   sum_adj;
  logic [g7e_pkg::SampleW-1:0] mid;

  function automatic g7e_pkg::beat_t mk_beat(logic [g7e_pkg::SampleW-1:0] s,
                                             logic il, logic fl);
    g7e_pkg::beat_t b;
    b.sample     = s;
    b.item_last  = il;
    b.frame_last = fl;
    return b;
  endfunction

  always_comb begin
    if (frame_len_i == '0) begin
      len = g7e_pkg::PosW'(1);
    end else if (frame_len_i > LenCap) begin
      len = LenCap;
    end else begin
      len = frame_len_i;
    end
    first = (pos_i == '0);
    last  = (pos_i >= len - g7e_pkg::PosW'(1));
  end

  // (held + s) / 2 toward zero: bump odd negative sums before the shift
  always_comb begin
    sum     = {held_i[g7e_pkg::SampleW-1], held_i} + {sample_i[g7e_pkg::SampleW-1], sample_i};
    sum_adj = sum + {{g7e_pkg::SampleW{1'b0}}, sum[g7e_pkg::SampleW] & sum[0]};
    mid     = sum_adj[g7e_pkg::SampleW:1];
  end

  always_comb begin
    plan_o = '0;
    plan_o.frame_end = last;
    if (!upsample_i) begin
      plan_o.beats[0] = mk_beat(sample_i, 1'b1, last);
      plan_o.last_idx = 2'd0;
    end else if (first) begin
      plan_o.beats[0] = mk_beat(sample_i, !last, 1'b0);
      plan_o.beats[1] = mk_beat(sample_i, 1'b1, 1'b1);
      plan_o.last_idx = last ? 2'd1 : 2'd0;
    end else begin
      plan_o.beats[0] = mk_beat(mid, 1'b0, 1'b0);
      plan_o.beats[1] = mk_beat(sample_i, !last, 1'b0);
      plan_o.beats[2] = mk_beat(sample_i, 1'b1, 1'b1);
      plan_o.last_idx = last ? 2'd2 : 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: design/g711_expand_upsample2x.sv
// Path: an accepted input beat is held in the input register, then its plan is
// loaded into the result register. Throughput: one input item per cycle with
// upsampling off while out_stall_i is low; with it on, an item makes 1 to 3 result
// beats, which the one output register sends out one per cycle when not stalled.
// Reset: asynchronous, active low; clears pipeline valids, frame position,
// held sample and loads register defaults (mu-law, upsample off, frame 1024).
`default_nettype none

`include "g711_expand_upsample2x_defines.svh"

module g711_expand_upsample2x #(
  parameter int unsigned FRAME_LEN_MAX = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  code_byte_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      sample_out_o,
  output logic             item_last_o,
  output logic             frame_last_o
);

  // Configuration registers
  g7e_pkg::law_e               law_q;
  logic                        ups_q;
  logic [g7e_pkg::PosW-1:0]    flen_q;

  // Input register
  logic [7:0]                  code_q;
  logic                        code_vld_q;

  // Frame state
  logic [g7e_pkg::SampleW-1:0] held_q;
  logic [g7e_pkg::PosW-1:0]    pos_q;

  // Result register: up to three planned beats, sent one per cycle when not stalled
  g7e_pkg::beat_t [2:0]        beats_q;
  logic [1:0]                  last_idx_q;
  logic [1:0]                  idx_q;
  logic                        out_vld_q;

  logic [g7e_pkg::SampleW-1:0] sample;
  g7e_pkg::plan_t              plan;
  g7e_pkg::beat_t              cur;
  logic                        in_take;
  logic                        out_take;
  logic                        out_done;
  logic                        load;

  g7e_expand u_expand (
    .code_i   (code_q),
    .law_i    (law_q),
    .sample_o (sample)
  );

  g7e_plan #(
    .FRAME_LEN_MAX (FRAME_LEN_MAX)
  ) u_plan (
    .sample_i    (sample),
    .held_i      (held_q),
    .pos_i       (pos_q),
    .frame_len_i (flen_q),
    .upsample_i  (ups_q),
    .plan_o      (plan)
  );

  // Handshake: a result beat leaves when not stalled; the last beat of a bundle
  // frees the result register for the next item in the same cycle.
  assign out_take = out_vld_q && !out_stall_i;
  assign out_done = out_take && (idx_q == last_idx_q);
  assign load     = code_vld_q && (!out_vld_q || out_done);

  // Hold the input beat while the result register cannot take its plan.
  assign in_stall_o = code_vld_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q  <= g7e_pkg::LawMulaw;
      ups_q  <= 1'b0;
      flen_q <= g7e_pkg::FrameLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        g7e_pkg::CfgLawSelect:   law_q  <= g7e_pkg::law_e'(cfg_data_i[0]);
        g7e_pkg::CfgUpsampleEn:  ups_q  <= cfg_data_i[0];
        g7e_pkg::CfgFrameLength: flen_q <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Input stage: capture the code byte, free the slot when its plan loads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_vld_q <= 1'b0;
    end else if (in_take) begin
      code_vld_q <= 1'b1;
    end else if (load) begin
      code_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      code_q <= code_byte_i;
    end
  end

  // Frame state advances once per item, when its plan is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pos_q  <= '0;
    end else if (load) begin
      held_q <= sample;
      pos_q  <= plan.frame_end ? '0 : pos_q + g7e_pkg::PosW'(1);
    end
  end

  // Result stage control: load a plan, advance through its beats, drop when done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      idx_q      <= 2'd0;
      last_idx_q <= 2'd0;
    end else if (load) begin
      out_vld_q  <= 1'b1;
      idx_q      <= 2'd0;
      last_idx_q <= plan.last_idx;
    end else if (out_done) begin
      out_vld_q  <= 1'b0;
    end else if (out_take) begin
      idx_q      <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beats_q <= plan.beats;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    cur = beats_q[0];
      2'd1:    cur = beats_q[1];
      2'd2:    cur = beats_q[2];
      default: cur = beats_q[2];
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = cur.sample;
  assign item_last_o  = cur.item_last;
  assign frame_last_o = cur.frame_last;

  `G7E_ASSERT_NOW(a_idx_in_range, out_vld_q, idx_q <= last_idx_q, "beat index past plan end")
  `G7E_ASSERT_NOW(a_item_last_on_final, out_vld_q, item_last_o == (idx_q == last_idx_q),
                  "item_last not on the final beat of an item")
  `G7E_ASSERT_NOW(a_frame_implies_item, out_vld_q && frame_last_o, item_last_o,
                  "frame_last without item_last")
  `G7E_ASSERT_NEXT(a_load_starts, load, out_vld_q && (idx_q == 2'd0),
                   "loaded plan does not start at its first beat")
  `G7E_ASSERT_NEXT(a_advance, out_take && !out_done,
                   out_vld_q && (idx_q == $past(idx_q) + 2'd1), "beat index did not advance")

endmodule

`default_nettype wire
